[hw/rtl/dqsp_pkg.sv]
`default_nettype none
package dqsp_pkg;

  localparam int MAX_NAME = 255;
  localparam int NAME_LEN_W = $clog2(MAX_NAME + 1);

  localparam int HEADER_LEN = 12;
  localparam int MAX_LABEL = 63;
  localparam int TRAILER_LEN = 4;

  // output queue, power of two so the pointers wrap by themselves
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // header byte offsets
  localparam logic [3:0] HDR_ID_HI = 4'd0;
  localparam logic [3:0] HDR_ID_LO = 4'd1;
  localparam logic [3:0] HDR_FLAGS = 4'd2;
  localparam logic [3:0] HDR_QD_HI = 4'd4;
  localparam logic [3:0] HDR_QD_LO = 4'd5;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_SHORT = 4'd1;
  localparam logic [3:0] ST_NOT_QUERY = 4'd2;
  localparam logic [3:0] ST_QDCOUNT = 4'd3;
  localparam logic [3:0] ST_BAD_LABEL = 4'd4;
  localparam logic [3:0] ST_TRAILER_LEN = 4'd5;
  localparam logic [3:0] ST_QTYPE = 4'd6;
  localparam logic [3:0] ST_QCLASS = 4'd7;
  localparam logic [3:0] ST_NAME_LONG = 4'd8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  name_char;
    logic [15:0] query_id;
    logic [3:0]  status;
    logic        out_last;
  } out_item_t;

  // results of one byte: a name character, a verdict, or both (character first)
  typedef struct packed {
    logic      char_valid;
    logic      verdict_valid;
    out_item_t char_item;
    out_item_t verdict_item;
  } push_t;

endpackage
`default_nettype wire

[hw/rtl/dqsp_parser.sv]
`default_nettype none
module dqsp_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire dqsp_pkg::in_item_t in_data,
  output dqsp_pkg::push_t        push
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN,
    PH_DATA,
    PH_TRAILER,
    PH_SKIP
  } phase_t;

  phase_t phase, phase_next;
  logic [3:0] header_count, header_count_next;
  logic [15:0] message_id, message_id_next;
  logic [1:0] header_flags_ok, header_flags_ok_next;
  logic [5:0] label_left, label_left_next;
  logic first_label, first_label_next;
  logic [dqsp_pkg::NAME_LEN_W-1:0] name_length, name_length_next;
  logic [31:0] trailer_bytes, trailer_bytes_next;
  logic [2:0] trailer_count, trailer_count_next;
  logic [3:0] error_code, error_code_next;

  logic [7:0] b;
  logic [3:0] st;
  logic [15:0] id;

  assign b = in_data.in_byte;

  always_comb begin
    phase_next = phase;
    header_count_next = header_count;
    message_id_next = message_id;
    header_flags_ok_next = header_flags_ok;
    label_left_next = label_left;
    first_label_next = first_label;
    name_length_next = name_length;
    trailer_bytes_next = trailer_bytes;
    trailer_count_next = trailer_count;
    error_code_next = error_code;
    st = dqsp_pkg::ST_OK;
    id = 16'd0;

    push.char_valid = 1'b0;
    push.char_item.out_kind = dqsp_pkg::KIND_CHAR;
    push.char_item.name_char = b;
    push.char_item.query_id = 16'd0;
    push.char_item.status = dqsp_pkg::ST_OK;
    push.char_item.out_last = 1'b0;

    unique case (phase)
      PH_HEADER: begin
        case (header_count)
          dqsp_pkg::HDR_ID_HI: message_id_next[15:8] = b;
          dqsp_pkg::HDR_ID_LO: message_id_next[7:0] = b;
          dqsp_pkg::HDR_FLAGS: if (!b[7]) header_flags_ok_next[0] = 1'b1;
          dqsp_pkg::HDR_QD_HI: if (b == 8'd0) header_flags_ok_next[1] = 1'b1;
          dqsp_pkg::HDR_QD_LO: if (b != 8'd1) header_flags_ok_next[1] = 1'b0;
          default: ;
        endcase
        header_count_next = header_count + 4'd1;
        if (header_count == 4'(dqsp_pkg::HEADER_LEN - 1)) begin
          if (!header_flags_ok_next[0]) begin
            error_code_next = dqsp_pkg::ST_NOT_QUERY;
            phase_next = PH_SKIP;
          end else if (!header_flags_ok_next[1]) begin
            error_code_next = dqsp_pkg::ST_QDCOUNT;
            phase_next = PH_SKIP;
          end else begin
            phase_next = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        if (b == 8'd0) begin
          phase_next = PH_TRAILER;
        end else if (b > 8'(dqsp_pkg::MAX_LABEL)) begin
          error_code_next = dqsp_pkg::ST_BAD_LABEL;
          phase_next = PH_SKIP;
        end else if (!first_label &&
                     name_length >= dqsp_pkg::NAME_LEN_W'(dqsp_pkg::MAX_NAME)) begin
          error_code_next = dqsp_pkg::ST_NAME_LONG;
          phase_next = PH_SKIP;
        end else begin
          if (!first_label) begin
            push.char_valid = 1'b1;
            push.char_item.name_char = dqsp_pkg::DOT_CHAR;
            name_length_next = name_length + dqsp_pkg::NAME_LEN_W'(1);
          end
          first_label_next = 1'b0;
          label_left_next = b[5:0];
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (name_length >= dqsp_pkg::NAME_LEN_W'(dqsp_pkg::MAX_NAME)) begin
          error_code_next = dqsp_pkg::ST_NAME_LONG;
          phase_next = PH_SKIP;
        end else begin
          push.char_valid = 1'b1;
          name_length_next = name_length + dqsp_pkg::NAME_LEN_W'(1);
          label_left_next = label_left - 6'd1;
          if (label_left == 6'd1) phase_next = PH_LEN;
        end
      end
      PH_TRAILER: begin
        trailer_bytes_next = {trailer_bytes[23:0], b};
        if (trailer_count < 3'(dqsp_pkg::TRAILER_LEN + 1)) begin
          trailer_count_next = trailer_count + 3'd1;
        end
      end
      PH_SKIP: ;
      default: ;
    endcase

    // verdict reflects the state after this byte
    if (phase_next == PH_HEADER) begin
      st = dqsp_pkg::ST_SHORT;
    end else begin
      id = message_id_next;
      if (error_code_next != dqsp_pkg::ST_OK) begin
        st = error_code_next;
      end else if (phase_next == PH_LEN) begin
        st = dqsp_pkg::ST_TRAILER_LEN;
      end else if (phase_next == PH_TRAILER) begin
        if (trailer_count_next != 3'(dqsp_pkg::TRAILER_LEN)) begin
          st = dqsp_pkg::ST_TRAILER_LEN;
        end else if (trailer_bytes_next[31:16] != 16'd1) begin
          st = dqsp_pkg::ST_QTYPE;
        end else if (trailer_bytes_next[15:0] != 16'd1) begin
          st = dqsp_pkg::ST_QCLASS;
        end else begin
          st = dqsp_pkg::ST_OK;
        end
      end else begin
        st = dqsp_pkg::ST_BAD_LABEL;
      end
    end

    push.verdict_valid = in_data.in_last;
    push.verdict_item.out_kind = dqsp_pkg::KIND_VERDICT;
    push.verdict_item.name_char = 8'd0;
    push.verdict_item.query_id = id;
    push.verdict_item.status = st;
    push.verdict_item.out_last = 1'b1;

    // rearm for the next message
    if (in_data.in_last) begin
      phase_next = PH_HEADER;
      header_count_next = 4'd0;
      message_id_next = 16'd0;
      header_flags_ok_next = 2'd0;
      label_left_next = 6'd0;
      first_label_next = 1'b1;
      name_length_next = '0;
      trailer_bytes_next = 32'd0;
      trailer_count_next = 3'd0;
      error_code_next = dqsp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      header_count <= 4'd0;
      message_id <= 16'd0;
      header_flags_ok <= 2'd0;
      label_left <= 6'd0;
      first_label <= 1'b1;
      name_length <= '0;
      trailer_bytes <= 32'd0;
      trailer_count <= 3'd0;
      error_code <= dqsp_pkg::ST_OK;
    end else if (accept) begin
      phase <= phase_next;
      header_count <= header_count_next;
      message_id <= message_id_next;
      header_flags_ok <= header_flags_ok_next;
      label_left <= label_left_next;
      first_label <= first_label_next;
      name_length <= name_length_next;
      trailer_bytes <= trailer_bytes_next;
      trailer_count <= trailer_count_next;
      error_code <= error_code_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/dqsp_out_queue.sv]
`default_nettype none
module dqsp_out_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire dqsp_pkg::push_t    push,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dqsp_pkg::out_item_t     out_data
);

  dqsp_pkg::out_item_t entries [dqsp_pkg::QUEUE_DEPTH];
  logic [dqsp_pkg::QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [dqsp_pkg::QUEUE_PTR_W:0] count;
  logic pop;
  logic push_char, push_verdict;
  logic [1:0] n_push;
  logic [dqsp_pkg::QUEUE_PTR_W-1:0] verdict_ptr;

  assign push_char = wr_en && push.char_valid;
  assign push_verdict = wr_en && push.verdict_valid;
  assign n_push = {1'b0, push_char} + {1'b0, push_verdict};
  // verdict goes right after the character when both are written
  assign verdict_ptr = push_char ? wr_ptr + dqsp_pkg::QUEUE_PTR_W'(1) : wr_ptr;

  assign out_valid = (count != '0);
  assign out_data = entries[rd_ptr];
  assign pop = out_valid && out_ready;
  // a byte may add two results, so keep two slots free before taking one
  assign room = (count <= (dqsp_pkg::QUEUE_PTR_W + 1)'(dqsp_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_char) entries[wr_ptr] <= push.char_item;
    if (push_verdict) entries[verdict_ptr] <= push.verdict_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + dqsp_pkg::QUEUE_PTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + dqsp_pkg::QUEUE_PTR_W'(1);
      count <= count + (dqsp_pkg::QUEUE_PTR_W + 1)'(n_push)
                     - (dqsp_pkg::QUEUE_PTR_W + 1)'(pop);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/dns_query_stream_parser.sv]
`default_nettype none
// Streaming DNS query parser. Takes one message byte per transfer (in_last on
// the final byte) and returns the question name one character per transfer,
// with a dot between labels, followed by a single verdict carrying the
// message id and a status; the name is only meaningful when the status is ok.
// A byte is taken every cycle while the consumer keeps up: the header, label
// and trailer checks are all combinational parser logic, and results go
// into a four-entry output queue. in_ready drops while fewer than two queue
// slots are free, so the final byte of a message that also ends a label
// (one character plus the verdict) adds two entries to the queue.
module dns_query_stream_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dqsp_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dqsp_pkg::out_item_t     out_data
);

  dqsp_pkg::push_t push;
  logic accept;

  assign accept = in_valid && in_ready;

  dqsp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .push    (push)
  );

  dqsp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
